// ----- design/tlptw_pkg.sv -----
// Shared types and constants for the two-level page table writer.
// Holds the request, result and internal work item layouts and the status codes.
// No dependencies.
package tlptw_pkg;

  localparam int unsigned DIR_ENTRIES   = 4096;
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned SLOT_W        = 12;
  localparam int unsigned ENT_W         = 8;
  localparam int unsigned DIR_W         = 9;

  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_TABLE = 2'd1;
  localparam logic [1:0] STATUS_FAULT    = 2'd2;

  // small-page descriptor type bits, coarse descriptor type bits
  localparam logic [11:0] SMALL_PAGE_TAG = 12'h002;
  localparam logic [31:0] COARSE_TAG     = 32'h0000_0001;

  typedef struct packed {
    logic        command;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
    logic [11:0] page_flags;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        table_allocated;
    logic [31:0] first_level_descriptor;
    logic [31:0] second_level_descriptor;
  } out_item_t;

  // classified request as queued between front and back
  typedef struct packed {
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic [ENT_W-1:0]  ent;
    logic [31:0]       page_desc;
  } work_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

// ----- design/tlptw_front.sv -----
// Request front end: accepts requests, splits the virtual address, builds the
// small-page descriptor and holds classified requests in a two-entry queue.
// Depends on tlptw_pkg.
module tlptw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlptw_pkg::in_item_t  in_data,
  output logic                 q_valid,
  output tlptw_pkg::work_t     q_item,
  input  tlptw_pkg::back_ctl_t ctl
);

  tlptw_pkg::work_t q_mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             push;
  tlptw_pkg::work_t item;

  assign in_stall = (cnt_r == 2'd2) || ctl.clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_comb begin
    item.command   = in_data.command;
    item.slot      = in_data.virt_addr[31:20];
    item.ent       = in_data.virt_addr[19:12];
    item.page_desc = {in_data.phys_addr[31:12], in_data.page_flags | tlptw_pkg::SMALL_PAGE_TAG};
  end

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = ctl.pop ? !rd_ptr_r : rd_ptr_r;
    unique case ({push, ctl.pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ----- design/tlptw_back.sv -----
// Request back end: owns the directory and coarse table memories, runs the
// clearing pass after reset, executes map and lookup requests, holds the result.
// Depends on tlptw_pkg.
module tlptw_back #(
  parameter int unsigned NUM_TABLES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [31:0]           pool_base,
  input  logic                  q_valid,
  input  tlptw_pkg::work_t      q_item,
  output tlptw_pkg::back_ctl_t  ctl,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tlptw_pkg::out_item_t  out_data
);

  localparam int unsigned TBL_W      = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int unsigned PIDX_W     = TBL_W + tlptw_pkg::ENT_W;
  localparam int unsigned POOL_DEPTH = NUM_TABLES * tlptw_pkg::TABLE_ENTRIES;
  localparam int unsigned CLR_DEPTH  = (POOL_DEPTH > tlptw_pkg::DIR_ENTRIES) ?
                                       POOL_DEPTH : tlptw_pkg::DIR_ENTRIES;
  localparam int unsigned CLR_W      = $clog2(CLR_DEPTH);
  localparam int unsigned CNT_W      = $clog2(NUM_TABLES + 1);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_DIR   = 4'b0100,
    ST_POOL  = 4'b1000
  } state_t;

  function automatic logic [31:0] first_desc(input logic [31:0] base, input logic [7:0] tbl);
    logic [31:0] sum;
    sum = {base[31:10], 10'b0} + {14'b0, tbl, 10'b0};
    return sum | tlptw_pkg::COARSE_TAG;
  endfunction

  logic [tlptw_pkg::DIR_W-1:0] dir_mem  [tlptw_pkg::DIR_ENTRIES];
  logic [31:0]                 pool_mem [POOL_DEPTH];

  state_t                      state_r, state_nxt;
  logic [CLR_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]            next_free_r, next_free_nxt;
  tlptw_pkg::work_t            work_r, work_nxt;
  logic [tlptw_pkg::DIR_W-1:0] dir_rd_r;
  logic [31:0]                 pool_rd_r;
  logic                        out_valid_r, out_valid_nxt;
  tlptw_pkg::out_item_t        out_data_r, res;

  logic                           out_free, load_out;
  logic                           dir_valid, exhausted;
  logic [7:0]                     dir_tbl, new_tbl, use_tbl;
  logic [PIDX_W-1:0]              pidx;
  logic                           clr_in_dir, clr_in_pool;
  logic                           dir_we, dir_re, pool_we, pool_re;
  logic [tlptw_pkg::SLOT_W-1:0]   dir_wa;
  logic [tlptw_pkg::DIR_W-1:0]    dir_wd;
  logic [PIDX_W-1:0]              pool_wa;
  logic [31:0]                    pool_wd;

  assign out_free    = !out_valid_r || !out_stall;
  assign dir_valid   = dir_rd_r[8];
  assign dir_tbl     = dir_rd_r[7:0];
  assign exhausted   = (next_free_r == CNT_W'(NUM_TABLES));
  assign new_tbl     = 8'(next_free_r);
  assign use_tbl     = dir_valid ? dir_tbl : new_tbl;
  assign pidx        = {use_tbl[TBL_W-1:0], work_r.ent};
  assign clr_in_dir  = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(tlptw_pkg::DIR_ENTRIES));
  assign clr_in_pool = ({1'b0, clr_cnt_r} < (CLR_W + 1)'(POOL_DEPTH));

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    next_free_nxt = next_free_r;
    work_nxt      = work_r;
    ctl.clearing  = (state_r == ST_CLEAR);
    ctl.pop       = 1'b0;
    dir_we        = 1'b0;
    dir_re        = 1'b0;
    pool_we       = 1'b0;
    pool_re       = 1'b0;
    dir_wa        = work_r.slot;
    dir_wd        = {1'b1, new_tbl};
    pool_wa       = pidx;
    pool_wd       = work_r.page_desc;
    load_out      = 1'b0;
    res           = '0;

    unique case (state_r)
      ST_CLEAR: begin
        dir_we      = clr_in_dir;
        dir_wa      = clr_cnt_r[tlptw_pkg::SLOT_W-1:0];
        dir_wd      = '0;
        pool_we     = clr_in_pool;
        pool_wa     = clr_cnt_r[PIDX_W-1:0];
        pool_wd     = '0;
        clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        if (clr_cnt_r == CLR_W'(CLR_DEPTH - 1)) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (q_valid) begin
          dir_re    = 1'b1;
          ctl.pop   = 1'b1;
          work_nxt  = q_item;
          state_nxt = ST_DIR;
        end
      end
      ST_DIR: begin
        if (work_r.command == tlptw_pkg::CMD_LOOKUP) begin
          if (dir_valid) begin
            pool_re   = 1'b1;
            state_nxt = ST_POOL;
          end else if (out_free) begin
            load_out   = 1'b1;
            res.status = tlptw_pkg::STATUS_FAULT;
            state_nxt  = ST_FETCH;
          end
        end else if (out_free) begin
          // hold all writes until the result register can take the outcome
          load_out  = 1'b1;
          state_nxt = ST_FETCH;
          if (!dir_valid && exhausted) begin
            res.status = tlptw_pkg::STATUS_NO_TABLE;
          end else begin
            if (!dir_valid) begin
              dir_we              = 1'b1;
              next_free_nxt       = next_free_r + CNT_W'(1);
              res.table_allocated = 1'b1;
            end
            pool_we                     = 1'b1;
            res.status                  = tlptw_pkg::STATUS_OK;
            res.first_level_descriptor  = first_desc(pool_base, use_tbl);
            res.second_level_descriptor = work_r.page_desc;
          end
        end
      end
      ST_POOL: begin
        if (out_free) begin
          load_out                    = 1'b1;
          res.status                  = (pool_rd_r == 32'd0) ? tlptw_pkg::STATUS_FAULT :
                                                               tlptw_pkg::STATUS_OK;
          res.first_level_descriptor  = first_desc(pool_base, dir_tbl);
          res.second_level_descriptor = pool_rd_r;
          state_nxt                   = ST_FETCH;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      next_free_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    if (load_out) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_wa] <= dir_wd;
    end
    if (dir_re) begin
      dir_rd_r <= dir_mem[q_item.slot];
    end
  end

  always_ff @(posedge clk) begin
    if (pool_we) begin
      pool_mem[pool_wa] <= pool_wd;
    end
    if (pool_re) begin
      pool_rd_r <= pool_mem[pidx];
    end
  end

`ifndef SYNTHESIS
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    next_free_r <= CNT_W'(NUM_TABLES))
    else $error("table counter beyond pool size");

  a_free_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (next_free_r != $past(next_free_r)) |->
      (next_free_r == $past(next_free_r) + CNT_W'(1)) && ($past(state_r) == ST_DIR))
    else $error("table counter moved outside an allocation");

  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.table_allocated |->
      (out_data_r.status == tlptw_pkg::STATUS_OK) && out_data_r.first_level_descriptor[0])
    else $error("allocation reported without a good coarse descriptor");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !ctl.pop)
    else $error("request taken during clearing pass");
`endif

endmodule

// ----- design/two_level_page_table_writer_core.sv -----
// Two-level page table writer (short-descriptor style, 4 KiB pages). After
// reset the block sweeps its directory and coarse table memories, one entry per
// cycle, over max(NUM_TABLES*256, 4096) entries (65536 at the default), and
// stalls requests meanwhile; cfg writes to pool_base are taken at any time but
// should only be issued while the block is idle. A map request passes through
// a directory read, then a directory and table write in the back end; a lookup
// passes through a directory read, a table read and the result, and skips the
// table read when its slot is empty. A two-entry queue in front and a result
// register behind let either side stall independently.
// Depends on tlptw_pkg, tlptw_front and tlptw_back.
module two_level_page_table_writer_core #(
  parameter int unsigned NUM_TABLES = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  tlptw_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output tlptw_pkg::out_item_t out_data,
  input  logic                 cfg_wr_en,
  input  logic [31:0]          cfg_wr_data
);

  logic [31:0]          pool_base_r, pool_base_nxt;
  logic                 q_valid;
  tlptw_pkg::work_t     q_item;
  tlptw_pkg::back_ctl_t ctl;

  assign pool_base_nxt = cfg_wr_en ? cfg_wr_data : pool_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r <= 32'd0;
    end else begin
      pool_base_r <= pool_base_nxt;
    end
  end

  tlptw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .ctl      (ctl)
  );

  tlptw_back #(
    .NUM_TABLES (NUM_TABLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pool_base (pool_base_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .ctl       (ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
